[design/atpo_pkg.sv]
`default_nettype none

package atpo_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

    // ratio r = floor(lo * 2^16 / hi), 0..1.0 inclusive
    localparam int RATIO_FRAC  = 16;
    localparam int RATIO_BITS  = RATIO_FRAC + 1;
    localparam int SUM_WIDTH   = RATIO_BITS + 2;

    // angle accumulator, Q32, signed, holds up to 2pi + pi/4
    localparam int Q32_FRAC       = 32;
    localparam int ANG_Q32_WIDTH  = 37;

    localparam logic signed [ANG_Q32_WIDTH-1:0] Q32_HPI  = 37'sd6746518852;
    localparam logic signed [ANG_Q32_WIDTH-1:0] Q32_PI   = 37'sd13493037705;
    localparam logic signed [ANG_Q32_WIDTH-1:0] Q32_3HPI = Q32_PI + Q32_HPI;
    localparam logic signed [ANG_Q32_WIDTH-1:0] Q32_2PI  = Q32_PI + Q32_PI;

    localparam logic [15:0] COEF_3 = 16'd21845;
    localparam logic [15:0] COEF_5 = 16'd13107;
    localparam logic [15:0] COEF_7 = 16'd9362;

    typedef enum logic [2:0] {
        BASE_ZERO,
        BASE_HPI,
        BASE_PI,
        BASE_3HPI,
        BASE_2PI
    } t_base;

    typedef struct packed {
        t_base base;
        logic  neg;
        logic  origin;
    } t_side;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } t_coord;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle;
        logic                   origin_flag;
    } t_result;

endpackage

`default_nettype wire

[design/atpo_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per stage: stage 0 gives the integer bit,
// stages 1..RATIO_FRAC give the fraction bits.
module atpo_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [atpo_pkg::COORD_WIDTH-1:0]    i_lo,
    input  wire logic [atpo_pkg::COORD_WIDTH-1:0]    i_hi,
    input  wire atpo_pkg::t_side                     i_side,
    output logic                                     o_valid,
    output logic [atpo_pkg::RATIO_BITS-1:0]          o_quot,
    output atpo_pkg::t_side                          o_side
);

    localparam int CW    = atpo_pkg::COORD_WIDTH;
    localparam int QW    = atpo_pkg::RATIO_BITS;
    localparam int STEPS = atpo_pkg::RATIO_FRAC;

    logic [STEPS:0]        r_valid;
    logic [CW-1:0]         r_rem  [0:STEPS-1];
    logic [CW-1:0]         r_hi   [0:STEPS-1];
    logic [QW-1:0]         r_quot [0:STEPS];
    atpo_pkg::t_side       r_side [0:STEPS];

    logic [CW-1:0]         n_rem  [0:STEPS-1];
    logic [QW-1:0]         n_quot [0:STEPS];
    logic [CW:0]           n_shift [1:STEPS];
    logic [CW:0]           n_diff  [1:STEPS];
    logic                  n_bit   [1:STEPS];
    logic                  n_top;

    always_comb begin
        // lo <= hi, so the integer bit is set only when they are equal
        n_top     = (i_lo >= i_hi);
        n_rem[0]  = n_top ? (i_lo - i_hi) : i_lo;
        n_quot[0] = {{(QW-1){1'b0}}, n_top};
        for (int s = 1; s <= STEPS; s++) begin
            n_shift[s] = {r_rem[s-1], 1'b0};
            n_diff[s]  = n_shift[s] - {1'b0, r_hi[s-1]};
            n_bit[s]   = (n_shift[s] >= {1'b0, r_hi[s-1]});
            n_quot[s]  = {r_quot[s-1][QW-2:0], n_bit[s]};
            if (s < STEPS) begin
                n_rem[s] = n_bit[s] ? n_diff[s][CW-1:0] : n_shift[s][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem[0];
            r_hi[0]   <= i_hi;
            r_quot[0] <= n_quot[0];
            r_side[0] <= i_side;
            for (int s = 1; s <= STEPS; s++) begin
                r_quot[s] <= n_quot[s];
                r_side[s] <= r_side[s-1];
                if (s < STEPS) begin
                    r_rem[s] <= n_rem[s];
                    r_hi[s]  <= r_hi[s-1];
                end
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_quot  = r_quot[STEPS];
    assign o_side  = r_side[STEPS];

endmodule

`default_nettype wire

[design/atpo_poly.sv]
`default_nettype none

// p = r - r^3/3 + r^5/5 - r^7/7 in Q16, six stages, one multiplier per path
module atpo_poly (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [atpo_pkg::RATIO_BITS-1:0]       i_r,
    input  wire atpo_pkg::t_side                       i_side,
    output logic                                       o_valid,
    output logic signed [atpo_pkg::SUM_WIDTH-1:0]      o_p,
    output atpo_pkg::t_side                            o_side
);

    localparam int QW = atpo_pkg::RATIO_BITS;
    localparam int SW = atpo_pkg::SUM_WIDTH;
    localparam int NSTAGE = 6;
    localparam logic [2*QW-1:0] HALF = (2*QW)'(1) << (atpo_pkg::RATIO_FRAC - 1);

    localparam logic [QW-1:0] C3 = QW'(atpo_pkg::COEF_3);
    localparam logic [QW-1:0] C5 = QW'(atpo_pkg::COEF_5);
    localparam logic [QW-1:0] C7 = QW'(atpo_pkg::COEF_7);

    function automatic logic [QW-1:0] mul_q16(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] prod;
        logic [2*QW-1:0] rnd;
        prod = a * b;
        rnd  = prod + HALF;
        return rnd[atpo_pkg::RATIO_FRAC +: QW];
    endfunction

    logic [NSTAGE-1:0]      r_valid;
    atpo_pkg::t_side        r_side [0:NSTAGE-1];

    logic [QW-1:0]          r_s1_r, r_s1_r2;
    logic [QW-1:0]          r_s2_r, r_s2_r2, r_s2_r3;
    logic [QW-1:0]          r_s3_r, r_s3_r2, r_s3_r5, r_s3_t3;
    logic [QW-1:0]          r_s4_r7, r_s4_t5;
    logic signed [SW-1:0]   r_s4_sum;
    logic [QW-1:0]          r_s5_t7;
    logic signed [SW-1:0]   r_s5_sum;
    logic signed [SW-1:0]   r_s6_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NSTAGE-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < NSTAGE; s++) begin
                r_side[s] <= r_side[s-1];
            end

            r_s1_r   <= i_r;
            r_s1_r2  <= mul_q16(i_r, i_r);

            r_s2_r   <= r_s1_r;
            r_s2_r2  <= r_s1_r2;
            r_s2_r3  <= mul_q16(r_s1_r2, r_s1_r);

            r_s3_r   <= r_s2_r;
            r_s3_r2  <= r_s2_r2;
            r_s3_r5  <= mul_q16(r_s2_r3, r_s2_r2);
            r_s3_t3  <= mul_q16(C3, r_s2_r3);

            r_s4_r7  <= mul_q16(r_s3_r5, r_s3_r2);
            r_s4_t5  <= mul_q16(C5, r_s3_r5);
            r_s4_sum <= $signed({2'b00, r_s3_r}) - $signed({2'b00, r_s3_t3});

            r_s5_t7  <= mul_q16(C7, r_s4_r7);
            r_s5_sum <= r_s4_sum + $signed({2'b00, r_s4_t5});

            r_s6_p   <= r_s5_sum - $signed({2'b00, r_s5_t7});
        end
    end

    assign o_valid = r_valid[NSTAGE-1];
    assign o_p     = r_s6_p;
    assign o_side  = r_side[NSTAGE-1];

endmodule

`default_nettype wire

[design/atan2_polynomial_octant.sv]
// channel   direction  valid    ready    payload
// --------  ---------  -------  -------  ---------------------------------
// coord     in         i_valid  o_ready  i_coord  (coord_x, coord_y)
// result    out        o_valid  i_ready  o_result (angle, origin_flag)
//
// One item enters per cycle while o_ready is high. 27 register stages: abs stage,
// octant stage, 17-stage bit-per-stage divider, 6-stage polynomial, base add,
// rounding output register.
// Reset (i_rst_n low at a clock edge) clears all valid bits; no clearing pass.
// A waiting result freezes the whole pipeline; o_ready is low only while
// o_valid is high and i_ready is low.
`default_nettype none

module atan2_polynomial_octant (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire atpo_pkg::t_coord  i_coord,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output atpo_pkg::t_result      o_result
);

    localparam int CW  = atpo_pkg::COORD_WIDTH;
    localparam int QW  = atpo_pkg::RATIO_BITS;
    localparam int SW  = atpo_pkg::SUM_WIDTH;
    localparam int AW  = atpo_pkg::ANG_Q32_WIDTH;
    localparam int OW  = atpo_pkg::ANGLE_WIDTH;
    localparam int SHR = atpo_pkg::Q32_FRAC - atpo_pkg::ANGLE_FRAC_BITS;
    localparam int PSH = atpo_pkg::Q32_FRAC - atpo_pkg::RATIO_FRAC;
    localparam logic [AW:0] OUT_HALF = (AW+1)'(1) << (SHR - 1);

    function automatic logic signed [AW-1:0] base_q32(input atpo_pkg::t_base b);
        logic signed [AW-1:0] v;
        case (b)
            atpo_pkg::BASE_ZERO: v = '0;
            atpo_pkg::BASE_HPI:  v = atpo_pkg::Q32_HPI;
            atpo_pkg::BASE_PI:   v = atpo_pkg::Q32_PI;
            atpo_pkg::BASE_3HPI: v = atpo_pkg::Q32_3HPI;
            atpo_pkg::BASE_2PI:  v = atpo_pkg::Q32_2PI;
            default:             v = '0;
        endcase
        return v;
    endfunction

    logic en;

    // stage A: magnitudes
    logic                  r_a_valid;
    logic [CW-1:0]         r_a_ax, r_a_ay;
    logic                  r_a_sx, r_a_sy;

    // stage B: octant decode
    logic                  r_b_valid;
    logic [CW-1:0]         r_b_lo, r_b_hi;
    atpo_pkg::t_side       r_b_side;
    logic [CW-1:0]         n_b_lo, n_b_hi;
    atpo_pkg::t_side       n_b_side;
    logic                  n_b_gt;

    logic                  div_valid;
    logic [QW-1:0]         div_quot;
    atpo_pkg::t_side       div_side;

    logic                  poly_valid;
    logic signed [SW-1:0]  poly_p;
    atpo_pkg::t_side       poly_side;

    // stage C: base +/- p
    logic                  r_c_valid;
    logic signed [AW-1:0]  r_c_ang;
    logic                  r_c_origin;
    logic signed [AW-1:0]  n_c_pq;
    logic signed [AW-1:0]  n_c_sum;

    logic                  r_out_valid;
    atpo_pkg::t_result     r_out_result;
    logic [AW:0]           n_out_rnd;
    logic [AW:0]           n_out_shr;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        n_b_gt = (r_a_ay > r_a_ax);
        n_b_lo = n_b_gt ? r_a_ax : r_a_ay;
        n_b_hi = n_b_gt ? r_a_ay : r_a_ax;
        n_b_side.origin = (r_a_ax == '0) && (r_a_ay == '0);
        case ({r_a_sx, r_a_sy})
            2'b00: begin
                n_b_side.base = n_b_gt ? atpo_pkg::BASE_HPI : atpo_pkg::BASE_ZERO;
                n_b_side.neg  = n_b_gt;
            end
            2'b10: begin
                n_b_side.base = n_b_gt ? atpo_pkg::BASE_HPI : atpo_pkg::BASE_PI;
                n_b_side.neg  = !n_b_gt;
            end
            2'b11: begin
                n_b_side.base = n_b_gt ? atpo_pkg::BASE_3HPI : atpo_pkg::BASE_PI;
                n_b_side.neg  = n_b_gt;
            end
            default: begin
                n_b_side.base = n_b_gt ? atpo_pkg::BASE_3HPI : atpo_pkg::BASE_2PI;
                n_b_side.neg  = !n_b_gt;
            end
        endcase
    end

    always_comb begin
        n_c_pq  = AW'(poly_p) <<< PSH;
        n_c_sum = poly_side.neg ? (base_q32(poly_side.base) - n_c_pq)
                                : (base_q32(poly_side.base) + n_c_pq);
    end

    assign n_out_rnd = {1'b0, r_c_ang} + OUT_HALF;
    assign n_out_shr = n_out_rnd >> SHR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= poly_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // negation in CW bits: the most negative value maps to 2^(CW-1)
            r_a_ax <= i_coord.coord_x[CW-1] ? (CW'(0) - i_coord.coord_x) : i_coord.coord_x;
            r_a_ay <= i_coord.coord_y[CW-1] ? (CW'(0) - i_coord.coord_y) : i_coord.coord_y;
            r_a_sx <= i_coord.coord_x[CW-1];
            r_a_sy <= i_coord.coord_y[CW-1];

            r_b_lo   <= n_b_lo;
            r_b_hi   <= n_b_hi;
            r_b_side <= n_b_side;

            r_c_ang    <= n_c_sum[AW-1] ? '0 : n_c_sum;
            r_c_origin <= poly_side.origin;

            r_out_result.angle       <= r_c_origin ? '0 : n_out_shr[OW-1:0];
            r_out_result.origin_flag <= r_c_origin;
        end
    end

    atpo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_lo    (r_b_lo),
        .i_hi    (r_b_hi),
        .i_side  (r_b_side),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_side  (div_side)
    );

    atpo_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_r     (div_quot),
        .i_side  (div_side),
        .o_valid (poly_valid),
        .o_p     (poly_p),
        .o_side  (poly_side)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;

endmodule

`default_nettype wire

[design/atpo_chk.sv]
`default_nettype none

module atpo_chk (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              o_ready,
    input  wire atpo_pkg::t_coord  i_coord,
    input  wire logic              o_valid,
    input  wire logic              i_ready,
    input  wire atpo_pkg::t_result o_result
);

    localparam int AW  = atpo_pkg::ANG_Q32_WIDTH;
    localparam int OW  = atpo_pkg::ANGLE_WIDTH;
    localparam int SHR = atpo_pkg::Q32_FRAC - atpo_pkg::ANGLE_FRAC_BITS;
    localparam logic [AW:0] TWO_PI_RND =
        ({1'b0, atpo_pkg::Q32_2PI} + ((AW+1)'(1) << (SHR - 1))) >> SHR;
    localparam logic [OW-1:0] ANGLE_MAX = TWO_PI_RND[OW-1:0];

    // the origin case never carries an angle
    a_origin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.origin_flag |-> o_result.angle == '0)
        else $error("origin result with nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.angle <= ANGLE_MAX)
        else $error("angle above 2pi");

    // input side is never blocked while the output register is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result dropped or changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_coord))
        else $error("input transfer dropped or changed while stalled");

endmodule

bind atan2_polynomial_octant atpo_chk u_atpo_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_coord  (i_coord),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);

`default_nettype wire
